FILE: rtl/gvt_pkg.sv
// shared constants, command codes, types and the map size clamp for the grid visibility triage block
// no dependencies
`default_nettype none

package gvt_pkg;

  localparam int COORD_W = 6;                 // column / row index bits
  localparam int DIM_W   = 7;                 // map size register bits
  localparam int TILE_AW = 2 * COORD_W;       // tile memory address bits
  localparam int RB_AW   = 2 + COORD_W;       // row buffer address: bank and column
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // row buffer banks: two ping-pong rows plus the viewpoint row
  localparam logic [1:0] BANK_A      = 2'd0;
  localparam logic [1:0] BANK_CENTER = 2'd2;

  typedef struct packed {
    logic               we;
    logic [TILE_AW-1:0] addr;
    logic [1:0]         data;
  } cls_wr_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gvt_ram.sv
// generic one-write one-read synchronous memory, registered read data
// no dependencies
`default_nettype none

module gvt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/gvt_sweep.sv
// visibility sweep sequencer: viewpoint row, then rows outward up and down
// uses gvt_pkg and gvt_ram (row buffer banks); reads transparency, writes classes
`default_nettype none

module gvt_sweep import gvt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] px_i,
  input  logic [COORD_W-1:0] py_i,
  input  logic [DIM_W-1:0]   w_i,
  input  logic [DIM_W-1:0]   h_i,
  output logic [TILE_AW-1:0] tr_raddr_o,
  input  logic               tr_rdata_i,
  output cls_wr_t            cls_wr_o,
  output logic               done_o
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_DONE} state_e;

  state_e             st_q, st_d;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d, x_q, x_d, y_q, y_d;
  logic [DIM_W-1:0]   w_q, w_d, h_q, h_d, d_q, d_d;
  logic               center_q, center_d, side_q, side_d, dir_q, dir_d;
  logic               cb_q, cb_d, cpx_q, cpx_d;
  logic [2:0]         pb_q, pb_d, nb_q, nb_d, c0_q, c0_d, p0_q, p0_d;
  logic [1:0]         pbk_q, pbk_d, nbk_q, nbk_d;

  logic               rb_we;
  logic [RB_AW-1:0]   rb_waddr, rb_raddr;
  logic [2:0]         rb_wdata, rb_rdata;

  // outside the viewpoint row, prev and next banks always differ, so a write never meets the read in flight
  gvt_ram #(.WIDTH(3), .DEPTH(4 * (1 << COORD_W))) u_rowbuf (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (rb_waddr),
    .wdata_i (rb_wdata),
    .raddr_i (rb_raddr),
    .rdata_o (rb_rdata)
  );

  logic             at_px, px_last, x_last, in_cone, outer, clr;
  logic [DIM_W-1:0] dx;
  logic [2:0]       p, cv, rv, val;
  logic             maybe, always_v, step_end, to_right;
  logic [COORD_W-1:0] x_n;
  logic             side_n;

  assign tr_raddr_o = {y_q, x_q};
  assign rb_raddr   = {pbk_q, x_q};
  assign done_o     = (st_q == S_DONE);

  always_comb begin
    at_px   = (x_q == px_q);
    px_last = ({1'b0, px_q} == w_q - 7'd1);
    x_last  = ({1'b0, x_q} == w_q - 7'd1);
    dx      = side_q ? ({1'b0, x_q} - {1'b0, px_q}) : ({1'b0, px_q} - {1'b0, x_q});
    in_cone = (dx <= d_q);
    outer   = (dx >= d_q);
    clr     = tr_rdata_i;
    p       = rb_rdata;

    cv = (at_px || cb_q) ? {clr, 2'b11} : 3'b000;

    maybe    = (|(pb_q & 3'b101)) | (in_cone & |(p & 3'b101)) | (outer & |(nb_q & 3'b101));
    always_v = (|(pb_q & 3'b110)) & (!in_cone | |(p & 3'b110)) & (!outer | |(nb_q & 3'b110));
    if (at_px) begin
      // viewpoint column: carry the cached bit only through transparent tiles
      rv = {clr & p[2], p[1:0] & {2{p[2]}}};
    end else begin
      rv = {(maybe | always_v) & clr, always_v, maybe};
    end
    val = center_q ? cv : rv;

    step_end = 1'b0;
    to_right = 1'b0;
    x_n      = x_q;
    side_n   = side_q;
    if (at_px) begin
      if (px_q != '0) begin
        x_n = px_q - 6'd1;
        side_n = 1'b0;
      end else if (!px_last) begin
        x_n = px_q + 6'd1;
        side_n = 1'b1;
        to_right = 1'b1;
      end else begin
        step_end = 1'b1;
      end
    end else if (!side_q) begin
      if (x_q != '0) begin
        x_n = x_q - 6'd1;
      end else if (!px_last) begin
        x_n = px_q + 6'd1;
        side_n = 1'b1;
        to_right = 1'b1;
      end else begin
        step_end = 1'b1;
      end
    end else begin
      if (!x_last) x_n = x_q + 6'd1;
      else step_end = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    px_d = px_q; py_d = py_q; w_d = w_q; h_d = h_q;
    x_d = x_q; y_d = y_q; d_d = d_q;
    center_d = center_q; side_d = side_q; dir_d = dir_q;
    cb_d = cb_q; cpx_d = cpx_q;
    pb_d = pb_q; nb_d = nb_q; c0_d = c0_q; p0_d = p0_q;
    pbk_d = pbk_q; nbk_d = nbk_q;
    rb_we    = 1'b0;
    rb_waddr = {(center_q ? BANK_CENTER : nbk_q), x_q};
    rb_wdata = val;
    cls_wr_o = '{we: 1'b0, addr: {y_q, x_q}, data: val[1:0]};

    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          px_d = px_i; py_d = py_i; w_d = w_i; h_d = h_i;
          x_d = px_i; y_d = py_i;
          center_d = 1'b1; side_d = 1'b0;
          st_d = S_RD;
        end
      end
      S_RD: begin
        st_d = S_WR;
      end
      S_WR: begin
        rb_we       = 1'b1;
        cls_wr_o.we = 1'b1;
        if (at_px) begin
          cb_d = val[2]; cpx_d = val[2];
          nb_d = val; c0_d = val; pb_d = p; p0_d = p;
        end else if (to_right) begin
          cb_d = cpx_q; nb_d = c0_q; pb_d = p0_q;
        end else begin
          cb_d = val[2]; nb_d = val; pb_d = p;
        end
        if (!step_end) begin
          x_d = x_n; side_d = side_n;
          st_d = S_RD;
        end else begin
          x_d = px_q; side_d = 1'b0;
          st_d = S_RD;
          if (center_q) begin
            center_d = 1'b0;
            d_d = 7'd1; pbk_d = BANK_CENTER; nbk_d = BANK_A;
            if (py_q != '0) begin
              dir_d = 1'b0; y_d = py_q - 6'd1;
            end else if ({1'b0, py_q} != h_q - 7'd1) begin
              dir_d = 1'b1; y_d = py_q + 6'd1;
            end else begin
              st_d = S_DONE;
            end
          end else begin
            pbk_d = nbk_q;
            nbk_d = {1'b0, ~nbk_q[0]};
            d_d   = d_q + 7'd1;
            if (!dir_q) begin
              if (y_q != '0) begin
                y_d = y_q - 6'd1;
              end else if ({1'b0, py_q} != h_q - 7'd1) begin
                // upward rows done, restart below the viewpoint row
                dir_d = 1'b1; y_d = py_q + 6'd1; d_d = 7'd1;
                pbk_d = BANK_CENTER; nbk_d = BANK_A;
              end else begin
                st_d = S_DONE;
              end
            end else begin
              if ({1'b0, y_q} != h_q - 7'd1) y_d = y_q + 6'd1;
              else st_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; w_q <= w_d; h_q <= h_d;
    x_q <= x_d; y_q <= y_d; d_q <= d_d;
    center_q <= center_d; side_q <= side_d; dir_q <= dir_d;
    cb_q <= cb_d; cpx_q <= cpx_d;
    pb_q <= pb_d; nb_q <= nb_d; c0_q <= c0_d; p0_q <= p0_d;
    pbk_q <= pbk_d; nbk_q <= nbk_d;
  end

endmodule

`default_nettype wire

FILE: rtl/grid_visibility_triage.sv
// top level: config registers, command handling, tile memories, output register
// uses gvt_pkg, gvt_ram (transparency and class maps) and gvt_sweep
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  input    | in_valid_i / in_ready_o      | cmd_i, col_i, row_i, transparent_i
//  output   | out_valid_o / out_ready_i    | kind_o, tile_class_o, coord_error_o
//  config   | psel penable pwrite pready   | paddr, pwdata, prdata
//
// a write beat goes to the transparency map as it is accepted; a read passes through
// the T_READ state before its result is registered; a compute runs a memory read and a
// write-back step on every tile of the map, then registers the result after the sweep
// input is held off while a read or compute is in flight or a result waits untaken
// reset clears control only; maps hold garbage until written
`default_nettype none

module grid_visibility_triage import gvt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic               transparent_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [1:0]         tile_class_o,
  output logic               coord_error_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [1:0] {T_IDLE, T_READ, T_COMPUTE} state_e;

  state_e           st_q, st_d;
  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
  logic             out_valid_q, out_valid_d, kind_q, kind_d, err_q, err_d;
  logic [1:0]       class_q, class_d;
  logic             acc, bad, cfg_wr;

  logic               tr_we, tr_rdata;
  logic [TILE_AW-1:0] tr_raddr;
  logic [1:0]         cls_rdata;
  cls_wr_t            cls_wr;
  logic               sweep_start, sweep_done;

  assign w_eff = eff_dim(width_q);
  assign h_eff = eff_dim(height_q);
  assign bad   = ({1'b0, col_i} >= w_eff) || ({1'b0, row_i} >= h_eff);

  assign in_ready_o = (st_q == T_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign tr_we      = acc && (cmd_i == CMD_WRITE) && !bad;
  assign sweep_start = acc && (cmd_i == CMD_COMPUTE) && !bad;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(APB_DW-DIM_W){1'b0}}, height_q}
                                           : {{(APB_DW-DIM_W){1'b0}}, width_q};

  gvt_ram #(.WIDTH(1), .DEPTH(1 << TILE_AW)) u_trans (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i ({row_i, col_i}),
    .wdata_i (transparent_i),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  gvt_ram #(.WIDTH(2), .DEPTH(1 << TILE_AW)) u_class (
    .clk_i   (clk_i),
    .we_i    (cls_wr.we),
    .waddr_i (cls_wr.addr),
    .wdata_i (cls_wr.data),
    .raddr_i ({row_i, col_i}),
    .rdata_o (cls_rdata)
  );

  gvt_sweep u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sweep_start),
    .px_i       (col_i),
    .py_i       (row_i),
    .w_i        (w_eff),
    .h_i        (h_eff),
    .tr_raddr_o (tr_raddr),
    .tr_rdata_i (tr_rdata),
    .cls_wr_o   (cls_wr),
    .done_o     (sweep_done)
  );

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    class_d     = class_q;
    err_d       = err_q;
    case (st_q)
      T_IDLE: begin
        if (acc && cmd_i == CMD_COMPUTE) begin
          if (bad) begin
            out_valid_d = 1'b1; kind_d = KIND_DONE; class_d = 2'b00; err_d = 1'b1;
          end else begin
            st_d = T_COMPUTE;
          end
        end else if (acc && cmd_i == CMD_READ) begin
          if (bad) begin
            out_valid_d = 1'b1; kind_d = KIND_READ; class_d = 2'b00; err_d = 1'b1;
          end else begin
            st_d = T_READ;
          end
        end
      end
      T_READ: begin
        // class memory data for the accepted address lands this cycle
        out_valid_d = 1'b1; kind_d = KIND_READ; class_d = cls_rdata; err_d = 1'b0;
        st_d = T_IDLE;
      end
      T_COMPUTE: begin
        if (sweep_done) begin
          out_valid_d = 1'b1; kind_d = KIND_DONE; class_d = 2'b00; err_d = 1'b0;
          st_d = T_IDLE;
        end
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      out_valid_q <= 1'b0;
      width_q     <= MAX_DIM;
      height_q    <= MAX_DIM;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr[2] == REG_WIDTH) width_q <= pwdata[DIM_W-1:0];
      if (cfg_wr && paddr[2] == REG_HEIGHT) height_q <= pwdata[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    class_q <= class_d;
    err_q   <= err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign tile_class_o  = class_q;
  assign coord_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_cls_wr_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_wr.we |-> st_q == T_COMPUTE) else $error("class write outside compute");
  a_done_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_done |-> st_q == T_COMPUTE) else $error("sweep done while not computing");
  a_start_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_start |=> !out_valid_q) else $error("result pending while sweep runs");
`endif

endmodule

`default_nettype wire
